// ----- hdl/ipel_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants of the priority-sorted interrupt enable list
package ipel_pkg;

	localparam int NUM_MAIN       = 64;
	localparam int NUM_GPP        = 32;
	localparam int GROUP_SIZE     = 8;
	localparam int NUM_GROUPS     = NUM_GPP / GROUP_SIZE;
	localparam int GPP_GROUP_BASE = 24;
	localparam int IRQ_BITS       = $clog2(NUM_MAIN);
	localparam int COUNT_BITS     = 7;

	// request kinds
	localparam logic [1:0] KIND_EN_MAIN  = 2'd0;
	localparam logic [1:0] KIND_DIS_MAIN = 2'd1;
	localparam logic [1:0] KIND_EN_GPP   = 2'd2;
	localparam logic [1:0] KIND_DIS_GPP  = 2'd3;

	// register index on the config port
	localparam logic REG_TABLE_TRACKING = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic accept;
		logic decode;
		logic scan;
		logic load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic has_op;
		logic scan_done;
		logic out_free;
	} dp_status_t;

endpackage

// ----- hdl/ipel_ram.sv -----
`timescale 1ns / 1ps
// generic single-write, single-read RAM with registered read data
module ipel_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/ipel_ctrl.sv -----
`timescale 1ns / 1ps
// sequencer for decode, list sweep and result hand-off
module ipel_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  ipel_pkg::dp_status_t   status,
	output ipel_pkg::ctrl_cmd_t    cmd
);

	import ipel_pkg::*;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) state_next = ST_DECODE;
			end
			ST_DECODE: begin
				state_next = status.has_op ? ST_SCAN : ST_FINISH;
			end
			ST_SCAN: begin
				if (status.scan_done) state_next = ST_FINISH;
			end
			ST_FINISH: begin
				if (status.out_free) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:   cmd.accept = req_valid;
			ST_DECODE: cmd.decode = 1'b1;
			ST_SCAN:   cmd.scan   = 1'b1;
			ST_FINISH: cmd.load   = status.out_free;
			default:   cmd        = '0;
		endcase
	end

	assign req_stall = (state_q != ST_IDLE);

endmodule

// ----- hdl/ipel_dp.sv -----
`timescale 1ns / 1ps
// masks, group bits, sorted list storage with its sweep, and result register
module ipel_dp #(
	parameter int LIST_DEPTH = 64,
	parameter int PRIO_BITS  = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ipel_pkg::ctrl_cmd_t   cmd,
	output ipel_pkg::dp_status_t  status,
	input  logic                  tracking,
	input  logic [1:0]            kind,
	input  logic [5:0]            irq_number,
	input  logic [7:0]            priority_req,
	input  logic                  rsp_stall,
	output logic                  rsp_valid,
	output logic [63:0]           main_mask,
	output logic [31:0]           gpp_mask,
	output logic [6:0]            active_count,
	output logic [5:0]            top_irq,
	output logic                  top_valid,
	output logic                  request_error
);

	import ipel_pkg::*;

	localparam int AW = $clog2(LIST_DEPTH);
	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam int EW = IRQ_BITS + PRIO_BITS;

	// latched request
	logic [1:0]           kind_q;
	logic [IRQ_BITS-1:0]  num_q;
	logic [PRIO_BITS-1:0] prio_q;

	// architectural state
	logic [NUM_MAIN-1:0]   main_en_q;
	logic [NUM_GPP-1:0]    gpp_en_q;
	logic [NUM_MAIN-1:0]   in_list_q;
	logic [GROUP_SIZE-1:0] grp_bits_q [NUM_GROUPS];
	logic [CW-1:0]         cnt_q;
	logic [IRQ_BITS-1:0]   top_q;
	logic                  err_q;

	// planned list operation
	logic                ins_q;
	logic                rem_q;
	logic [IRQ_BITS-1:0] tgt_q;

	// sweep state
	logic [CW-1:0] rd_ptr_q;
	logic          rd_pend_s1;
	logic [AW-1:0] wr_ptr_s1;
	logic [EW-1:0] carry_q;
	logic          placed_q;
	logic          found_q;

	// result register
	logic                  rsp_valid_q;
	logic [NUM_MAIN-1:0]   main_mask_q;
	logic [NUM_GPP-1:0]    gpp_mask_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [IRQ_BITS-1:0]   top_irq_q;
	logic                  top_valid_q;
	logic                  req_err_q;

	// decode
	logic                  is_gpp;
	logic                  gpp_bad;
	logic [1:0]            grp;
	logic [2:0]            grp_bit;
	logic [IRQ_BITS-1:0]   grp_entry;
	logic [GROUP_SIZE-1:0] grp_cur;
	logic [GROUP_SIZE-1:0] grp_set;
	logic [GROUP_SIZE-1:0] grp_clr;
	logic                  want_ins;
	logic                  want_rem;
	logic [IRQ_BITS-1:0]   tgt;
	logic                  do_ins;
	logic                  do_rem;

	// ram and sweep
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [EW-1:0]        ram_wdata;
	logic [EW-1:0]        ram_rdata;
	logic [IRQ_BITS-1:0]  d_idx;
	logic [PRIO_BITS-1:0] d_prio;
	logic                 rd_issue;
	logic                 take_carry;
	logic                 set_found;
	logic                 scan_done;

	assign is_gpp    = (kind_q == KIND_EN_GPP) || (kind_q == KIND_DIS_GPP);
	assign gpp_bad   = is_gpp && num_q[5];
	assign grp       = num_q[4:3];
	assign grp_bit   = num_q[2:0];
	assign grp_entry = IRQ_BITS'(GPP_GROUP_BASE + int'(grp));
	assign grp_cur   = grp_bits_q[grp];
	assign grp_set   = grp_cur | (GROUP_SIZE'(1) << grp_bit);
	assign grp_clr   = grp_cur & ~(GROUP_SIZE'(1) << grp_bit);

	always_comb begin
		want_ins = 1'b0;
		want_rem = 1'b0;
		tgt      = num_q;
		unique case (kind_q)
			KIND_EN_MAIN:  want_ins = tracking;
			KIND_DIS_MAIN: want_rem = tracking;
			KIND_EN_GPP: begin
				tgt      = grp_entry;
				want_ins = tracking && !gpp_bad && (grp_cur == '0);
			end
			KIND_DIS_GPP: begin
				tgt      = grp_entry;
				want_rem = tracking && !gpp_bad && (grp_clr == '0);
			end
			default: begin
				want_ins = 1'b0;
				want_rem = 1'b0;
			end
		endcase
	end

	// a full list drops the insert, an absent entry skips the remove
	assign do_ins = want_ins && !in_list_q[tgt] && (cnt_q < CW'(LIST_DEPTH));
	assign do_rem = want_rem && in_list_q[tgt];

	assign d_idx    = ram_rdata[EW-1:PRIO_BITS];
	assign d_prio   = ram_rdata[PRIO_BITS-1:0];
	assign rd_issue = (rd_ptr_q < cnt_q);
	assign scan_done = !rd_issue && !rd_pend_s1;

	// insert ripples a carried entry down from its slot; remove pulls later entries up
	always_comb begin
		ram_we     = 1'b0;
		ram_waddr  = wr_ptr_s1;
		ram_wdata  = carry_q;
		take_carry = 1'b0;
		set_found  = 1'b0;
		if (cmd.scan) begin
			if (rd_pend_s1) begin
				if (ins_q && (placed_q || (prio_q > d_prio))) begin
					ram_we     = 1'b1;
					take_carry = 1'b1;
				end
				if (rem_q) begin
					if (found_q) begin
						ram_we    = 1'b1;
						ram_waddr = wr_ptr_s1 - 1'b1;
						ram_wdata = ram_rdata;
					end else if (d_idx == tgt_q) begin
						set_found = 1'b1;
					end
				end
			end else if (!rd_issue && ins_q) begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q[AW-1:0];
			end
		end
	end

	ipel_ram #(
		.WIDTH (EW),
		.DEPTH (LIST_DEPTH)
	) u_list_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_ptr_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// request latch and sweep payload
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q <= kind;
			num_q  <= irq_number;
			prio_q <= PRIO_BITS'(priority_req);
		end
		if (cmd.decode) begin
			tgt_q   <= tgt;
			carry_q <= {tgt, prio_q};
			err_q   <= gpp_bad;
		end
		if (cmd.scan) begin
			wr_ptr_s1 <= rd_ptr_q[AW-1:0];
			if (take_carry) carry_q <= ram_rdata;
			if (ram_we && (ram_waddr == '0)) top_q <= ram_wdata[EW-1:PRIO_BITS];
		end
		if (cmd.load) begin
			main_mask_q <= main_en_q;
			gpp_mask_q  <= gpp_en_q;
			count_q     <= COUNT_BITS'(cnt_q);
			top_irq_q   <= (cnt_q != '0) ? top_q : '0;
			top_valid_q <= (cnt_q != '0);
			req_err_q   <= err_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_en_q   <= '0;
			gpp_en_q    <= '0;
			in_list_q   <= '0;
			grp_bits_q  <= '{default: '0};
			cnt_q       <= '0;
			ins_q       <= 1'b0;
			rem_q       <= 1'b0;
			rd_ptr_q    <= '0;
			rd_pend_s1  <= 1'b0;
			placed_q    <= 1'b0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.decode) begin
				unique case (kind_q)
					KIND_EN_MAIN:  main_en_q[num_q] <= 1'b1;
					KIND_DIS_MAIN: main_en_q[num_q] <= 1'b0;
					KIND_EN_GPP: begin
						if (!gpp_bad) begin
							gpp_en_q[num_q[4:0]] <= 1'b1;
							if (tracking) grp_bits_q[grp] <= grp_set;
						end
					end
					KIND_DIS_GPP: begin
						if (!gpp_bad) begin
							gpp_en_q[num_q[4:0]] <= 1'b0;
							if (tracking) grp_bits_q[grp] <= grp_clr;
						end
					end
					default: main_en_q <= main_en_q;
				endcase
				if (do_ins) in_list_q[tgt] <= 1'b1;
				if (do_rem) in_list_q[tgt] <= 1'b0;
				ins_q      <= do_ins;
				rem_q      <= do_rem;
				rd_ptr_q   <= '0;
				rd_pend_s1 <= 1'b0;
				placed_q   <= 1'b0;
				found_q    <= 1'b0;
			end
			if (cmd.scan) begin
				rd_pend_s1 <= rd_issue;
				if (rd_issue) rd_ptr_q <= rd_ptr_q + 1'b1;
				if (take_carry) placed_q <= 1'b1;
				if (set_found) found_q <= 1'b1;
				if (scan_done) begin
					if (ins_q) cnt_q <= cnt_q + 1'b1;
					if (rem_q) cnt_q <= cnt_q - 1'b1;
				end
			end
			if (cmd.load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign status.has_op    = do_ins || do_rem;
	assign status.scan_done = scan_done;
	assign status.out_free  = !rsp_valid_q || !rsp_stall;

	assign rsp_valid     = rsp_valid_q;
	assign main_mask     = main_mask_q;
	assign gpp_mask      = gpp_mask_q;
	assign active_count  = count_q;
	assign top_irq       = top_irq_q;
	assign top_valid     = top_valid_q;
	assign request_error = req_err_q;

endmodule

// ----- hdl/irq_priority_enable_list.sv -----
`timescale 1ns / 1ps
// top level of the priority-sorted interrupt enable list
//
// channel   direction  handshake              payload
// request   in         req_valid / req_stall  kind, irq_number, priority_req
// result    out        rsp_valid / rsp_stall  main_mask, gpp_mask, active_count,
//                                             top_irq, top_valid, request_error
// config    in         apb psel / penable     table_tracking at byte address 0
//
// one request at a time: accept, decode, a list ram sweep when the list changes, then
// load of the result register once the result channel is free
// the sweep passes the entries listed before the request through the single read port
// and the single write port of the list ram
// reset clears masks, group bits, count and handshakes; the list ram needs no clearing
// a stalled result holds while the next request is worked on, which then waits to load
module irq_priority_enable_list #(
	parameter int LIST_DEPTH = 64,
	parameter int PRIO_BITS  = 8
) (
	input  logic        clk,
	input  logic        arst_n,

	// request channel
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  kind,
	input  logic [5:0]  irq_number,
	input  logic [7:0]  priority_req,

	// result channel
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [63:0] main_mask,
	output logic [31:0] gpp_mask,
	output logic [6:0]  active_count,
	output logic [5:0]  top_irq,
	output logic        top_valid,
	output logic        request_error,

	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	import ipel_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;
	logic       tracking_q;
	logic       cfg_wr;

	// config register: list tracking on out of reset
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TABLE_TRACKING);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracking_q <= 1'b1;
		end else if (cfg_wr) begin
			tracking_q <= pwdata[0];
		end
	end

	// reads outside the register list return zero
	assign prdata = (paddr[2] == REG_TABLE_TRACKING) ? 32'(tracking_q) : '0;

	// sequencer
	ipel_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// masks, list storage and result register
	ipel_dp #(
		.LIST_DEPTH (LIST_DEPTH),
		.PRIO_BITS  (PRIO_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.tracking      (tracking_q),
		.kind          (kind),
		.irq_number    (irq_number),
		.priority_req  (priority_req),
		.rsp_stall     (rsp_stall),
		.rsp_valid     (rsp_valid),
		.main_mask     (main_mask),
		.gpp_mask      (gpp_mask),
		.active_count  (active_count),
		.top_irq       (top_irq),
		.top_valid     (top_valid),
		.request_error (request_error)
	);

endmodule

// ----- hdl/ipel_chk.sv -----
`timescale 1ns / 1ps
// port-level checker for the interrupt enable list, bound to the top level
module ipel_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_stall,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [63:0] main_mask,
	input logic [6:0]  active_count,
	input logic [5:0]  top_irq,
	input logic        top_valid
);

	// one request in flight: the channel closes right after a transaction
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while another is in flight");

	a_top_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (top_valid == (active_count != 7'd0)))
		else $error("top_valid disagrees with active_count");

	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !top_valid |-> (top_irq == 6'd0))
		else $error("empty list reports a top entry");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (active_count <= 7'd64))
		else $error("active_count above list capacity");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(main_mask))
		else $error("stalled result changed");

endmodule

bind irq_priority_enable_list ipel_chk u_ipel_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req_valid),
	.req_stall    (req_stall),
	.rsp_valid    (rsp_valid),
	.rsp_stall    (rsp_stall),
	.main_mask    (main_mask),
	.active_count (active_count),
	.top_irq      (top_irq),
	.top_valid    (top_valid)
);
